/* hdl/uic_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uic_pkg
// Shared types and constants for the unique index collector.
// ----------------------------------------------------------------------------
package uic_pkg;

   localparam int MAX_UNIQUE_DEF = 256;
   localparam int INDEX_W        = 32;
   localparam int SLOT_W         = 8;
   localparam int UCOUNT_W       = 9;

   typedef struct packed {
      logic [INDEX_W-1:0] index_value;
      logic               list_end;
   } req_type;

   typedef struct packed {
      logic                is_new;
      logic [SLOT_W-1:0]   slot;
      logic [UCOUNT_W-1:0] unique_count;
      logic                overflow;
      logic                last_out;
   } rsp_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DELIVER
   } uic_state_type;

endpackage

/* hdl/unique_index_collector_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// unique_index_collector_top
// A request is taken in idle, the table is then scanned from slot 0 up to a
// match or, on a miss, up to the stored count, and the result is delivered.
// A new request is taken only once the last response is issued; the single-port
// table memory is read one entry per cycle during the scan.
// Reset: synchronous; clears the stored count, the FSM and the response valid.
// The table is not cleared; only slots written in the current list are compared.
// ----------------------------------------------------------------------------
module unique_index_collector_top
   import uic_pkg::*;
#(
   parameter int MAX_UNIQUE = MAX_UNIQUE_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   localparam int AW = $clog2(MAX_UNIQUE);
   localparam int CW = $clog2(MAX_UNIQUE + 1);

   uic_state_type state_ff, state_in;

   logic [INDEX_W-1:0] value_ff, value_in;
   logic               last_ff, last_in;
   logic [CW-1:0]      issue_idx_ff, issue_idx_in;
   logic               cmp_valid_ff, cmp_valid_in;
   logic [AW-1:0]      cmp_idx_ff, cmp_idx_in;
   logic [CW-1:0]      count_ff, count_in;
   rsp_type            res_ff, res_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_data_ff, rsp_data_in;

   logic [INDEX_W-1:0] mem [MAX_UNIQUE];
   logic [INDEX_W-1:0] rd_data_ff;
   logic [AW-1:0]      mem_addr;
   logic               mem_we;

   logic               hit;
   logic               scan_end;
   logic               full;
   logic               out_free;
   logic [CW-1:0]      count_plus;

   assign hit        = cmp_valid_ff && (rd_data_ff == value_ff);
   assign scan_end   = (issue_idx_ff == count_ff);
   assign full       = (count_ff == CW'(MAX_UNIQUE));
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign count_plus = count_ff + CW'(1);

   // single-port table, registered read
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_addr] <= value_ff;
      end
      rd_data_ff <= mem[mem_addr];
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (hit || scan_end) begin
               state_in = ST_DELIVER;
            end
         end
         ST_DELIVER: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_stall    = 1'b1;
      mem_we       = 1'b0;
      mem_addr     = issue_idx_ff[AW-1:0];
      value_in     = value_ff;
      last_in      = last_ff;
      issue_idx_in = issue_idx_ff;
      cmp_valid_in = 1'b0;
      cmp_idx_in   = cmp_idx_ff;
      count_in     = count_ff;
      res_in       = res_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;

      unique case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               value_in     = req_data.index_value;
               last_in      = req_data.list_end;
               issue_idx_in = '0;
            end
         end
         ST_SCAN: begin
            if (hit) begin
               res_in.is_new       = 1'b0;
               res_in.slot         = SLOT_W'(cmp_idx_ff);
               res_in.unique_count = UCOUNT_W'(count_ff);
               res_in.overflow     = 1'b0;
               res_in.last_out     = last_ff;
               count_in            = last_ff ? '0 : count_ff;
            end else if (scan_end) begin
               res_in.is_new   = 1'b1;
               res_in.last_out = last_ff;
               if (full) begin
                  // drop the value, report overflow
                  res_in.slot         = '0;
                  res_in.unique_count = UCOUNT_W'(count_ff);
                  res_in.overflow     = 1'b1;
                  count_in            = last_ff ? '0 : count_ff;
               end else begin
                  mem_we              = 1'b1;
                  mem_addr            = count_ff[AW-1:0];
                  res_in.slot         = SLOT_W'(count_ff);
                  res_in.unique_count = UCOUNT_W'(count_plus);
                  res_in.overflow     = 1'b0;
                  count_in            = last_ff ? '0 : count_plus;
               end
            end else begin
               // issue the next read while comparing the previous one
               cmp_valid_in = 1'b1;
               cmp_idx_in   = issue_idx_ff[AW-1:0];
               issue_idx_in = issue_idx_ff + CW'(1);
            end
         end
         ST_DELIVER: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = res_ff;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         cmp_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         cmp_valid_ff <= cmp_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      value_ff     <= value_in;
      last_ff      <= last_in;
      issue_idx_ff <= issue_idx_in;
      cmp_idx_ff   <= cmp_idx_in;
      res_ff       <= res_in;
      rsp_data_ff  <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

/* tb/unique_index_collector_top_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// unique_index_collector_top_test
// Self-checking bench for the unique index collector. A directed table covers
// the index extremes, matches, stale entries after a list end and one-item
// lists. Random lists with repeats, a few lists that overflow the table, and
// random stalls on both channels follow. Every response is checked against the
// table's expected value for known rows, else against a distinct-value predictor.
// ----------------------------------------------------------------------------
module unique_index_collector_top_test
   import uic_pkg::*;
();

   localparam int TABLE_DEPTH = MAX_UNIQUE_DEF;
   localparam int ITEM_TARGET = 1400;
   localparam int CALM_TAIL   = 120;
   localparam int LONG_HOLD   = 400;
   localparam int QUIET_LIMIT = 4000;
   localparam int DIR_ROWS    = 16;

   typedef struct packed {
      req_type req;
      logic    known;
      rsp_type want;
   } stim_row_type;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_stall;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_stall;
   rsp_type rsp_data;

   // predictor state: distinct values of the current list
   logic [INDEX_W-1:0] seen_vals [TABLE_DEPTH];
   int                 seen_count;

   rsp_type      pending_rsp [$];
   stim_row_type dir_tab [DIR_ROWS];
   int           errors;
   int           items_sent;
   int           quiet_cycles;
   int           idle_pct;
   bit           calm;
   bit           hold_ask;
   logic         drv_known;
   rsp_type      drv_want;

   unique_index_collector_top #(
      .MAX_UNIQUE(TABLE_DEPTH)
   ) dut (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data (rsp_data)
   );

   initial clock = 1'b0;
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic rsp_type dedup_predict(input req_type r);
      rsp_type o;
      logic    found;
      int      k;
      o     = '0;
      found = 1'b0;
      for (k = 0; k < seen_count && !found; k++) begin
         if (seen_vals[k] == r.index_value) begin
            found  = 1'b1;
            o.slot = 8'(k);
         end
      end
      if (!found) begin
         o.is_new = 1'b1;
         if (seen_count < TABLE_DEPTH) begin
            seen_vals[seen_count] = r.index_value;
            o.slot                = 8'(seen_count);
            seen_count++;
         end else begin
            o.overflow = 1'b1;
         end
      end
      o.unique_count = 9'(seen_count);
      o.last_out     = r.list_end;
      if (r.list_end) seen_count = 0;
      return o;
   endfunction

   function automatic stim_row_type mk_row(input logic [INDEX_W-1:0] v, input logic e,
                                           input logic known, input logic n, input int s,
                                           input int c, input logic o);
      stim_row_type r;
      r.req.index_value   = v;
      r.req.list_end      = e;
      r.known             = known;
      r.want.is_new       = n;
      r.want.slot         = 8'(s);
      r.want.unique_count = 9'(c);
      r.want.overflow     = o;
      r.want.last_out     = e;
      return r;
   endfunction

   // check responses and predict on accepted requests; state moves at posedge
   always @(posedge clock) begin
      rsp_type w;
      rsp_type p;
      if (reset) begin
         quiet_cycles = 0;
         seen_count   = 0;
      end else begin
         quiet_cycles++;
         if (rsp_valid && !rsp_stall) begin
            quiet_cycles = 0;
            if (pending_rsp.size() == 0) begin
               errors++;
               if (errors <= 10)
                  $display("%0t: response with no request pending: new=%0d slot=%0d cnt=%0d",
                           $realtime, rsp_data.is_new, rsp_data.slot, rsp_data.unique_count);
            end else begin
               w = pending_rsp.pop_front();
               if (rsp_data !== w) begin
                  errors++;
                  if (errors <= 10) begin
                     $display("%0t: mismatch exp new=%0d slot=%0d cnt=%0d ovf=%0d last=%0d",
                              $realtime, w.is_new, w.slot, w.unique_count, w.overflow,
                              w.last_out);
                     $display("   got new=%0d slot=%0d cnt=%0d ovf=%0d last=%0d",
                              rsp_data.is_new, rsp_data.slot, rsp_data.unique_count,
                              rsp_data.overflow, rsp_data.last_out);
                  end
               end
            end
         end
         if (req_valid && !req_stall) begin
            quiet_cycles = 0;
            p = dedup_predict(req_data);
            pending_rsp.push_back(drv_known ? drv_want : p);
         end
      end
   end

   // receiver: random stall bursts, one long hold-off on request
   initial begin : rsp_side
      int n;
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_ask) begin
            hold_ask = 1'b0;
            rsp_stall <= 1'b1;
            repeat (LONG_HOLD - 1) @(negedge clock);
         end else if (!calm && $urandom_range(0, 99) < idle_pct) begin
            n = $urandom_range(1, 15);
            rsp_stall <= 1'b1;
            repeat (n - 1) @(negedge clock);
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   initial begin : watchdog
      while (quiet_cycles < QUIET_LIMIT) @(negedge clock);
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   // called at a negedge; returns at the negedge after acceptance
   task automatic offer_index(input logic [INDEX_W-1:0] v, input logic e,
                              input logic known, input rsp_type want);
      drv_known = known;
      drv_want  = want;
      req_data  <= '{index_value: v, list_end: e};
      req_valid <= 1'b1;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
      items_sent++;
   endtask

   task automatic idle_req(input int n);
      req_valid <= 1'b0;
      repeat (n) @(negedge clock);
   endtask

   task automatic pace_req;
      calm = (items_sent >= ITEM_TARGET - CALM_TAIL);
      if (!calm && $urandom_range(0, 99) < idle_pct) idle_req($urandom_range(1, 15));
   endtask

   task automatic wait_drained;
      req_valid <= 1'b0;
      do @(negedge clock); while (pending_rsp.size() != 0);
   endtask

   initial begin : req_side
      logic [INDEX_W-1:0] pool [8];
      logic [INDEX_W-1:0] base;
      logic [INDEX_W-1:0] stride;
      logic [INDEX_W-1:0] v;
      logic               e;
      int                 i;
      int                 k;
      int                 len;
      int                 kind;
      int                 nfresh;
      int                 goal;
      bit                 long_done;
      bit                 held;
      bit                 paused;

      reset      = 1'b1;
      req_valid  = 1'b0;
      req_data   = '0;
      errors     = 0;
      items_sent = 0;
      idle_pct   = 10;
      calm       = 1'b0;
      hold_ask   = 1'b0;
      drv_known  = 1'b0;
      drv_want   = '0;
      long_done  = 1'b0;
      held       = 1'b0;
      paused     = 1'b0;

      //                   index          end known new slot cnt ovf
      dir_tab[0]  = mk_row(32'h0000_0000, 1'b0, 1'b1, 1'b1, 0, 1, 1'b0);
      dir_tab[1]  = mk_row(32'hFFFF_FFFF, 1'b0, 1'b1, 1'b1, 1, 2, 1'b0);
      dir_tab[2]  = mk_row(32'h0000_0000, 1'b0, 1'b1, 1'b0, 0, 2, 1'b0);
      dir_tab[3]  = mk_row(32'hFFFF_FFFF, 1'b0, 1'b1, 1'b0, 1, 2, 1'b0);
      dir_tab[4]  = mk_row(32'h8000_0000, 1'b0, 1'b0, 1'b0, 0, 0, 1'b0);
      dir_tab[5]  = mk_row(32'h0000_0001, 1'b0, 1'b0, 1'b0, 0, 0, 1'b0);
      dir_tab[6]  = mk_row(32'h7FFF_FFFF, 1'b0, 1'b0, 1'b0, 0, 0, 1'b0);
      dir_tab[7]  = mk_row(32'h8000_0000, 1'b1, 1'b1, 1'b0, 2, 5, 1'b0);
      // stale entries from the closed list must not match
      dir_tab[8]  = mk_row(32'hFFFF_FFFF, 1'b0, 1'b1, 1'b1, 0, 1, 1'b0);
      dir_tab[9]  = mk_row(32'hFFFF_FFFF, 1'b1, 1'b1, 1'b0, 0, 1, 1'b0);
      dir_tab[10] = mk_row(32'h0000_0000, 1'b1, 1'b1, 1'b1, 0, 1, 1'b0);
      dir_tab[11] = mk_row(32'h5555_AAAA, 1'b0, 1'b1, 1'b1, 0, 1, 1'b0);
      dir_tab[12] = mk_row(32'hAAAA_5555, 1'b0, 1'b0, 1'b0, 0, 0, 1'b0);
      dir_tab[13] = mk_row(32'h5555_AAAA, 1'b0, 1'b0, 1'b0, 0, 0, 1'b0);
      dir_tab[14] = mk_row(32'h1234_5678, 1'b0, 1'b0, 1'b0, 0, 0, 1'b0);
      dir_tab[15] = mk_row(32'hAAAA_5555, 1'b1, 1'b0, 1'b0, 0, 0, 1'b0);

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      for (i = 0; i < DIR_ROWS; i++) begin
         pace_req();
         offer_index(dir_tab[i].req.index_value, dir_tab[i].req.list_end,
                     dir_tab[i].known, dir_tab[i].want);
      end

      while (items_sent < ITEM_TARGET) begin
         case ($urandom_range(0, 3))
            0: idle_pct = 0;
            1: idle_pct = 5;
            2: idle_pct = 20;
            default: idle_pct = 50;
         endcase
         if (!held && items_sent >= 400) begin
            held     = 1'b1;
            hold_ask = 1'b1;
         end
         if (!paused && items_sent >= 800) begin
            paused = 1'b1;
            wait_drained();
         end
         kind = $urandom_range(0, 99);
         if (!long_done || (kind < 2 && items_sent < ITEM_TARGET - 500)) begin
            // fill the table, then push new values past it mixed with repeats
            long_done = 1'b1;
            base      = $urandom;
            stride    = $urandom | 32'h1;
            nfresh    = 0;
            goal      = TABLE_DEPTH + $urandom_range(4, 20);
            while (nfresh < goal) begin
               if (nfresh == 0 || $urandom_range(0, 7) != 0) begin
                  v = base + 32'(nfresh) * stride;
                  nfresh++;
               end else begin
                  v = base + 32'($urandom_range(0, nfresh - 1)) * stride;
               end
               pace_req();
               offer_index(v, nfresh >= goal, 1'b0, '0);
            end
         end else begin
            len = (kind < 15) ? $urandom_range(17, 64) : $urandom_range(1, 16);
            for (k = 0; k < 8; k++) begin
               case ($urandom_range(0, 4))
                  0: pool[k] = $urandom;
                  1: pool[k] = 32'h0000_0000;
                  2: pool[k] = 32'hFFFF_FFFF;
                  3: pool[k] = $urandom_range(0, 15);
                  default: pool[k] = 32'h1 << $urandom_range(0, 31);
               endcase
            end
            for (k = 0; k < len; k++) begin
               v = ($urandom_range(0, 9) < 6) ? pool[$urandom_range(0, 7)] : $urandom;
               e = (k == len - 1);
               pace_req();
               offer_index(v, e, 1'b0, '0);
            end
         end
      end

      wait_drained();
      repeat (TABLE_DEPTH + 8) @(negedge clock);
      if (errors == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

/* files.f */
hdl/uic_pkg.sv
hdl/unique_index_collector_top.sv
tb/unique_index_collector_top_test.sv
